// ----- hdl/tsdi_pkg.sv -----
// Shared types, codes and constants of the touch stroke dot interpolator.
`default_nettype none

package tsdi_pkg;

  // Channel and port widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Field widths.
  localparam int COORD_W = 10;
  localparam int COLOR_W = 24;
  localparam int OSLOT_W = 7;

  // Arithmetic unit widths: squared distance, quotient and remainder.
  localparam int RAD_W  = 22;
  localparam int DIVN_W = 14;
  localparam int DEN_W  = 6;
  localparam int Q_W    = 14;
  localparam int REM_W  = 12;
  localparam int CNT_W  = 4;
  localparam int SQRT_STEPS = 11;
  localparam int DIV_STEPS  = 14;

  localparam int MAX_RESULTS  = 12;
  localparam int PALETTE_SIZE = 8;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR  = 3'd4;

  // Register reset values.
  localparam logic [5:0]  RST_MIN_STEP     = 6'd5;
  localparam logic [3:0]  RST_MAX_STEPS    = 4'd12;
  localparam logic [15:0] RST_COLOR_PERIOD = 16'd150;
  localparam logic [9:0]  RST_CANVAS_SIZE  = 10'd240;
  localparam logic [2:0]  RST_START_COLOR  = 3'd0;

  localparam logic [COLOR_W-1:0] PALETTE [PALETTE_SIZE] = '{
    24'hffd83d, 24'hff6b9d, 24'h7ec7ff, 24'ha8e6cf,
    24'hffaaa5, 24'hd7baff, 24'hffffff, 24'h3ec27a
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_CHK,
    ST_SQRT,
    ST_DIVS,
    ST_DOTX,
    ST_DOTY,
    ST_EMIT
  } state_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] rem;
  } unit_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/touch_stroke_dot_interpolator.sv -----
// Top level of the touch stroke dot interpolator: sequencer, state and output register.
`default_nettype none

// Each input request is one polling tick with a touch sample (command tick) or a clear or
// start command, and produces zero to twelve dot requests on the output, the final one of
// a tick marked by out_tlast. A dot carries its center, a palette color and a ring slot.
// A clear, a start, an unused code, a failed read, a release, an off-canvas sample or the
// first dot of a press needs no arithmetic, and a move shorter than the minimum step ends
// after the squares and the check in ST_CHK. A bridged move, after its squares, goes
// through one shared radix-2 unit that resolves one result bit per cycle: the ceiling
// square root (11 steps) and the step count division (14 steps), then for each dot its
// two coordinate divisions (14 steps each), for up to twelve dots. The output register
// decouples the sides: the block accepts a new request while the last dot of the previous
// one still waits to be taken, and a stalled output holds the sequencer at the dot it is
// about to hand over. Configuration writes are taken at any cycle and are meant to happen
// only while the block is idle.
module touch_stroke_dot_interpolator #(
  parameter int RING_SLOTS = 100
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata, lowest bit up: sample_ok, pressed, touch_x[9:0], touch_y[9:0], zero pad.
  input  logic [tsdi_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: command[1:0].
  input  logic [tsdi_pkg::IN_USER_W-1:0]  in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata, lowest bit up: dot_x[9:0], dot_y[9:0], dot_color[23:0], dot_slot[6:0],
  // zero pad.
  output logic [tsdi_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tlast: last_of_tick.
  output logic                            out_tlast,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [tsdi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsdi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tsdi_pkg::*;

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  // Configuration registers.
  logic [5:0]  min_step_r;
  logic [3:0]  max_steps_r;
  logic [15:0] color_period_r;
  logic [9:0]  canvas_size_r;
  logic [2:0]  start_color_r;

  // Architectural state.
  state_t              state_r, state_nxt;
  logic                have_last_r, have_last_nxt;
  logic [COORD_W-1:0]  last_x_r, last_x_nxt;
  logic [COORD_W-1:0]  last_y_r, last_y_nxt;
  logic [15:0]         period_r, period_nxt;
  logic [2:0]          pal_r, pal_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  // Working registers of one bridged move.
  logic [COORD_W-1:0]  x0_r, x0_nxt;
  logic [COORD_W-1:0]  y0_r, y0_nxt;
  logic [COORD_W-1:0]  adx_r, adx_nxt;
  logic [COORD_W-1:0]  ady_r, ady_nxt;
  logic                sx_r, sx_nxt;
  logic                sy_r, sy_nxt;
  logic [RAD_W-1:0]    d2_r, d2_nxt;
  logic [3:0]          steps_r, steps_nxt;
  logic [3:0]          i_r, i_nxt;
  logic [DIVN_W-1:0]   mx_r, mx_nxt;
  logic [DIVN_W-1:0]   my_r, my_nxt;
  logic [COORD_W-1:0]  dotx_r, dotx_nxt;
  logic [COORD_W-1:0]  doty_r, doty_nxt;
  logic                dlast_r, dlast_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  // Shared arithmetic unit.
  unit_req_t          unit_req;
  unit_rsp_t          unit_rsp;
  logic [RAD_W-1:0]   unit_num;
  logic [DEN_W-1:0]   unit_den;

  // Decoded input request.
  logic               in_acc;
  logic [1:0]         cmd;
  logic               ok;
  logic               pr;
  logic [COORD_W-1:0] tx;
  logic [COORD_W-1:0] ty;

  // Helper terms.
  logic signed [COORD_W:0] dxs;
  logic signed [COORD_W:0] dys;
  logic [COORD_W-1:0]      adx_in;
  logic [COORD_W-1:0]      ady_in;
  logic [COORD_W-1:0]      sq_in;
  logic [2*COORD_W-1:0]    sq;
  logic [5:0]              ms;
  logic [11:0]             msq;
  logic [3:0]              cap;
  logic [COORD_W:0]        root_ceil;
  logic [3:0]              steps_calc;
  logic [15:0]             pc_inc;
  logic [2:0]              pal_step;
  logic [SLOT_W-1:0]       slot_inc;
  logic [DIVN_W-1:0]       mx_sum;
  logic [DIVN_W-1:0]       my_sum;
  logic                    out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign ok        = in_tdata[0];
  assign pr        = in_tdata[1];
  assign tx        = in_tdata[11:2];
  assign ty        = in_tdata[21:12];

  assign dxs    = $signed({1'b0, tx}) - $signed({1'b0, last_x_r});
  assign dys    = $signed({1'b0, ty}) - $signed({1'b0, last_y_r});
  assign adx_in = dxs[COORD_W] ? COORD_W'(-dxs) : dxs[COORD_W-1:0];
  assign ady_in = dys[COORD_W] ? COORD_W'(-dys) : dys[COORD_W-1:0];

  // One squarer serves both axes, x in its first cycle and y in the next.
  assign sq_in = (state_r == ST_SQX) ? adx_r : ady_r;
  assign sq    = {{COORD_W{1'b0}}, sq_in} * {{COORD_W{1'b0}}, sq_in};

  // A zero minimum step acts as one; the cap is held to one through twelve.
  assign ms  = (min_step_r == '0) ? 6'd1 : min_step_r;
  assign msq = {6'b0, ms} * {6'b0, ms};
  assign cap = (max_steps_r == '0) ? 4'd1 :
               (max_steps_r > 4'(MAX_RESULTS)) ? 4'(MAX_RESULTS) : max_steps_r;

  // Ceiling root: the floor root plus one whenever a remainder is left over.
  assign root_ceil  = unit_rsp.q[COORD_W:0] + {{COORD_W{1'b0}}, (unit_rsp.rem != '0)};
  assign steps_calc = (unit_rsp.q == '0) ? 4'd1 :
                      (unit_rsp.q > Q_W'(cap)) ? cap : unit_rsp.q[3:0];

  assign pc_inc   = period_r + 16'd1;
  assign pal_step = (pal_r == 3'(PALETTE_SIZE - 1)) ? 3'd0 : pal_r + 3'd1;
  assign slot_inc = (slot_r == SLOT_W'(RING_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
  assign mx_sum   = mx_r + DIVN_W'(adx_r);
  assign my_sum   = my_r + DIVN_W'(ady_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    have_last_nxt = have_last_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    period_nxt    = period_r;
    pal_nxt       = pal_r;
    slot_nxt      = slot_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    d2_nxt        = d2_r;
    steps_nxt     = steps_r;
    i_nxt         = i_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    dotx_nxt      = dotx_r;
    doty_nxt      = doty_r;
    dlast_nxt     = dlast_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unit_req      = '{start: 1'b0, op: OP_DIV};
    unit_num      = '0;
    unit_den      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_CLEAR: begin
              slot_nxt      = '0;
              have_last_nxt = 1'b0;
            end
            CMD_START: begin
              slot_nxt      = '0;
              have_last_nxt = 1'b0;
              pal_nxt       = 3'(start_color_r % PALETTE_SIZE);
            end
            CMD_TICK: begin
              // The color counter advances on every tick, read or not.
              if (pc_inc >= color_period_r) begin
                period_nxt = '0;
                pal_nxt    = pal_step;
              end else begin
                period_nxt = pc_inc;
              end
              if (ok) begin
                if (!pr) begin
                  have_last_nxt = 1'b0;
                end else if ((tx < canvas_size_r) && (ty < canvas_size_r)) begin
                  // The last point moves to the sample even when no dot results.
                  have_last_nxt = 1'b1;
                  last_x_nxt    = tx;
                  last_y_nxt    = ty;
                  if (!have_last_r) begin
                    dotx_nxt  = tx;
                    doty_nxt  = ty;
                    dlast_nxt = 1'b1;
                    state_nxt = ST_EMIT;
                  end else begin
                    x0_nxt    = last_x_r;
                    y0_nxt    = last_y_r;
                    adx_nxt   = adx_in;
                    ady_nxt   = ady_in;
                    sx_nxt    = dxs[COORD_W];
                    sy_nxt    = dys[COORD_W];
                    state_nxt = ST_SQX;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SQX: begin
        d2_nxt    = RAD_W'(sq);
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        d2_nxt    = d2_r + RAD_W'(sq);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (d2_r >= RAD_W'(msq)) begin
          unit_req  = '{start: 1'b1, op: OP_SQRT};
          unit_num  = d2_r;
          state_nxt = ST_SQRT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SQRT: begin
        if (unit_rsp.done) begin
          unit_req  = '{start: 1'b1, op: OP_DIV};
          unit_num  = RAD_W'(root_ceil);
          unit_den  = ms;
          state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        if (unit_rsp.done) begin
          steps_nxt = steps_calc;
          i_nxt     = 4'd1;
          mx_nxt    = DIVN_W'(adx_r);
          my_nxt    = DIVN_W'(ady_r);
          unit_req  = '{start: 1'b1, op: OP_DIV};
          unit_num  = RAD_W'(adx_r);
          unit_den  = DEN_W'(steps_calc);
          state_nxt = ST_DOTX;
        end
      end
      ST_DOTX: begin
        if (unit_rsp.done) begin
          // Magnitude quotient with the sign put back truncates toward zero.
          dotx_nxt  = sx_r ? x0_r - unit_rsp.q[COORD_W-1:0] : x0_r + unit_rsp.q[COORD_W-1:0];
          unit_req  = '{start: 1'b1, op: OP_DIV};
          unit_num  = RAD_W'(my_r);
          unit_den  = DEN_W'(steps_r);
          state_nxt = ST_DOTY;
        end
      end
      ST_DOTY: begin
        if (unit_rsp.done) begin
          doty_nxt  = sy_r ? y0_r - unit_rsp.q[COORD_W-1:0] : y0_r + unit_rsp.q[COORD_W-1:0];
          dlast_nxt = (i_r == steps_r);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_DATA_W - 2*COORD_W - COLOR_W - OSLOT_W)'(0),
                           OSLOT_W'(slot_r), PALETTE[pal_r], doty_r, dotx_r};
          out_last_nxt  = dlast_r;
          slot_nxt      = slot_inc;
          if (dlast_r) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 4'd1;
            mx_nxt    = mx_sum;
            my_nxt    = my_sum;
            unit_req  = '{start: 1'b1, op: OP_DIV};
            unit_num  = RAD_W'(mx_sum);
            unit_den  = DEN_W'(steps_r);
            state_nxt = ST_DOTX;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  tsdi_divsqrt u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .num   (unit_num),
    .den   (unit_den),
    .rsp   (unit_rsp)
  );

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r     <= RST_MIN_STEP;
      max_steps_r    <= RST_MAX_STEPS;
      color_period_r <= RST_COLOR_PERIOD;
      canvas_size_r  <= RST_CANVAS_SIZE;
      start_color_r  <= RST_START_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_STEP:     min_step_r     <= cfg_wdata[5:0];
        CFG_MAX_STEPS:    max_steps_r    <= cfg_wdata[3:0];
        CFG_COLOR_PERIOD: color_period_r <= cfg_wdata[15:0];
        CFG_CANVAS_SIZE:  canvas_size_r  <= cfg_wdata[9:0];
        CFG_START_COLOR:  start_color_r  <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_last_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      period_r    <= '0;
      pal_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_last_r <= have_last_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      period_r    <= period_nxt;
      pal_r       <= pal_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers carry no reset.
  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    adx_r      <= adx_nxt;
    ady_r      <= ady_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    d2_r       <= d2_nxt;
    steps_r    <= steps_nxt;
    i_r        <= i_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    dotx_r     <= dotx_nxt;
    doty_r     <= doty_nxt;
    dlast_r    <= dlast_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The arithmetic unit is never left running when a new request can enter.
  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !unit_rsp.busy)
    else $error("arithmetic unit busy while the block accepts requests");

  // A finished result arrives only while the sequencer waits for one.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    unit_rsp.done |-> (state_r == ST_SQRT || state_r == ST_DIVS ||
                       state_r == ST_DOTX || state_r == ST_DOTY))
    else $error("arithmetic result arrived outside a wait state");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(RING_SLOTS - 1))
    else $error("ring slot pointer out of range");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (cmd == CMD_CLEAR || cmd == CMD_START) |=> (slot_r == '0) && !have_last_r)
    else $error("clear or start did not reset the stroke state");

  // Handing over the final dot of a tick returns the block to accepting requests.
  a_last_dot_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && out_free && dlast_r |=> in_tready && out_tvalid && out_tlast)
    else $error("final dot of a tick did not end the sequence");

endmodule

`default_nettype wire

// ----- hdl/tsdi_divsqrt.sv -----
// Shared radix-2 unit: restoring integer square root or unsigned division.
`default_nettype none

module tsdi_divsqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tsdi_pkg::unit_req_t       req,
  input  logic [tsdi_pkg::RAD_W-1:0] num,
  input  logic [tsdi_pkg::DEN_W-1:0] den,
  output tsdi_pkg::unit_rsp_t       rsp
);
  import tsdi_pkg::*;

  unit_op_t         op_r, op_nxt;
  logic [RAD_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic [Q_W-1:0] shifted;
  logic [Q_W-1:0] trial;
  logic [Q_W-1:0] diff;
  logic           ge;

  // Each step brings down one dividend bit or two radicand bits and makes one
  // compare and subtract against the divisor or the trial root.
  assign shifted = (op_r == OP_SQRT) ? {rem_r, num_r[RAD_W-1 -: 2]}
                                     : {1'b0, rem_r, num_r[RAD_W-1]};
  assign trial   = (op_r == OP_SQRT) ? {q_r[Q_W-3:0], 2'b01} : Q_W'(den_r);
  assign ge      = (shifted >= trial);
  assign diff    = shifted - trial;

  always_comb begin
    op_nxt   = op_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      op_nxt  = req.op;
      num_nxt = (req.op == OP_SQRT) ? num : {num[DIVN_W-1:0], (RAD_W-DIVN_W)'(0)};
      den_nxt = den;
      q_nxt   = '0;
      rem_nxt = '0;
      cnt_nxt = (req.op == OP_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      num_nxt  = (op_r == OP_SQRT) ? {num_r[RAD_W-3:0], 2'b00} : {num_r[RAD_W-2:0], 1'b0};
      q_nxt    = {q_r[Q_W-2:0], ge};
      rem_nxt  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.q    = q_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire
